// File: rtl/rvis_pkg.sv
// ---------------------------------------------------------------------------
// rvis_pkg: shared types and constants of the RV32I instruction-step core
// Opcodes, request codes, halt causes and the port bundles between modules.
// ---------------------------------------------------------------------------
package rvis_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_EXIT    = 2'd1;
  localparam logic [1:0] CAUSE_ILLEGAL = 2'd2;

  localparam logic [31:0] A7_PUTCHAR = 32'd1;
  localparam logic [31:0] A7_EXIT    = 32'd10;

  typedef struct packed {
    logic       wr;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

endpackage

// File: rtl/rv32i_instruction_step.sv
// ---------------------------------------------------------------------------
// rv32i_instruction_step: RV32I core stepped by requests
// A sequencer around a byte memory and a register file runs one request.
// ---------------------------------------------------------------------------
// Usage:
//   Drive in_* and pulse start while busy is low; the item is taken at that
//   edge. Request 0 writes a word to memory, 1 executes one instruction at
//   the pc, 2 reads a register, 3 only reports status.
//   Every item gives exactly one result: out_valid is high for one cycle
//   with the out_* fields; the receiver cannot stall, so none is held.
//   A status request, a dropped write or an execute on a halted core goes
//   straight to the result; a register read adds a register step, a word
//   write a memory pass, and an execute a fetch pass (none when the fetch
//   is out of range), decode and execute. An ECALL adds a system step, a
//   load in range a memory pass and writeback, a store in range a memory
//   pass. The byte-wide memory port moves each fetch, load or store one
//   byte at a time. A new item can be taken in the cycle its predecessor's
//   result is shown. After reset the memory is swept to zero, one byte per
//   cycle; busy stays high during the sweep. The register file comes up
//   with all zeros except x2 = MEM_BYTES - 4, pc 0, running.
// ---------------------------------------------------------------------------
module rv32i_instruction_step #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_mem_address,
  input  logic [31:0] in_write_word,
  input  logic [4:0]  in_reg_index,
  output logic        out_valid,
  output logic        out_halted,
  output logic [1:0]  out_halt_cause,
  output logic        out_char_valid,
  output logic [7:0]  out_char_out,
  output logic [31:0] out_pc_now,
  output logic [31:0] out_reg_value
);

  localparam int AW = $clog2(MEM_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MRD  = 4'd1;
  localparam logic [3:0] S_MWR  = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_EXE  = 4'd4;
  localparam logic [3:0] S_SYS  = 4'd5;
  localparam logic [3:0] S_LDW  = 4'd6;
  localparam logic [3:0] S_REG  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]    state_r, ret_r;
  logic [31:0]   pc_r;
  logic          run_r;
  logic [1:0]    cause_r;
  logic [31:0]   ins_r, data_r, wdata_r;
  logic [AW-1:0] mbase_r;
  logic [2:0]    span_r, cnt_r;
  logic          char_v_r;
  logic [7:0]    char_r;
  logic [31:0]   val_r;

  logic          ov_r, oh_r, ocv_r;
  logic [1:0]    oc_r;
  logic [7:0]    och_r;
  logic [31:0]   opc_r, oval_r;

  logic               clearing;
  logic [7:0]         mem_rdata;
  rvis_pkg::mem_req_t mreq;
  logic [AW-1:0]      maddr;
  rvis_pkg::rf_wr_t   rfw;
  logic [4:0]         ra_idx, rb_idx;
  logic [31:0]        a_val, b_val;

  // Whole-access range test on an unsigned 32-bit address, no wrap.
  function automatic logic in_rng(input logic [31:0] addr, input logic [2:0] span);
    return ({1'b0, addr} + 33'(span)) <= 33'(MEM_BYTES);
  endfunction

  // Instruction fields
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i, imm_s, imm_u, imm_b, imm_j;
  logic [31:0] pc4, opb, alu, ld_addr, st_addr, ld_val;
  logic        alt_eff, take;
  logic [4:0]  sh;
  logic [2:0]  acc_span;
  logic        ld_ok;

  always_comb begin
    op    = ins_r[6:0];
    rd    = ins_r[11:7];
    f3    = ins_r[14:12];
    alt   = ins_r[30];
    imm_i = {{20{ins_r[31]}}, ins_r[31:20]};
    imm_s = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    imm_u = {ins_r[31:12], 12'd0};
    imm_b = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    imm_j = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    pc4   = pc_r + 32'd4;

    // Immediate forms take imm_i as the second operand; only SRAI keeps bit 30.
    opb     = (op == rvis_pkg::OP_IMM) ? imm_i : b_val;
    alt_eff = (op == rvis_pkg::OP_IMM && f3 != 3'd5) ? 1'b0 : alt;
    sh      = opb[4:0];
    case (f3)
      3'd0:    alu = alt_eff ? a_val - opb : a_val + opb;
      3'd1:    alu = a_val << sh;
      3'd2:    alu = {31'd0, $signed(a_val) < $signed(opb)};
      3'd3:    alu = {31'd0, a_val < opb};
      3'd4:    alu = a_val ^ opb;
      3'd5:    alu = alt_eff ? 32'($signed(a_val) >>> sh) : a_val >> sh;
      3'd6:    alu = a_val | opb;
      default: alu = a_val & opb;
    endcase

    case (f3)
      3'd0:    take = a_val == b_val;
      3'd1:    take = a_val != b_val;
      3'd4:    take = $signed(a_val) < $signed(b_val);
      3'd5:    take = $signed(a_val) >= $signed(b_val);
      3'd6:    take = a_val < b_val;
      3'd7:    take = a_val >= b_val;
      default: take = 1'b0;
    endcase

    ld_addr  = a_val + imm_i;
    st_addr  = a_val + imm_s;
    acc_span = 3'b001 << f3[1:0];
    ld_ok    = (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5});

    case (f3)
      3'd0:    ld_val = {{24{data_r[7]}}, data_r[7:0]};
      3'd1:    ld_val = {{16{data_r[15]}}, data_r[15:0]};
      3'd2:    ld_val = data_r;
      3'd4:    ld_val = {24'd0, data_r[7:0]};
      3'd5:    ld_val = {16'd0, data_r[15:0]};
      default: ld_val = 32'd0;
    endcase
  end

  // Register file write: results in execute, load data in writeback.
  always_comb begin
    rfw.en   = 1'b0;
    rfw.idx  = rd;
    rfw.data = 32'd0;
    if (state_r == S_EXE) begin
      case (op)
        rvis_pkg::OP_LUI: begin
          rfw.en = 1'b1; rfw.data = imm_u;
        end
        rvis_pkg::OP_AUIPC: begin
          rfw.en = 1'b1; rfw.data = pc_r + imm_u;
        end
        rvis_pkg::OP_JAL: begin
          rfw.en = 1'b1; rfw.data = pc4;
        end
        rvis_pkg::OP_JALR: begin
          rfw.en = (f3 == 3'd0); rfw.data = pc4;
        end
        rvis_pkg::OP_IMM, rvis_pkg::OP_REG: begin
          rfw.en = 1'b1; rfw.data = alu;
        end
        // Out-of-range load: write zero without a memory pass.
        rvis_pkg::OP_LOAD: begin
          rfw.en = ld_ok && !in_rng(ld_addr, acc_span); rfw.data = 32'd0;
        end
        default: rfw.en = 1'b0;
      endcase
    end else if (state_r == S_LDW) begin
      rfw.en   = 1'b1;
      rfw.data = ld_val;
    end
    if (rd == 5'd0) begin
      rfw.en = 1'b0;
    end
  end

  // Read addresses: decode reads rs1/rs2 of the fetched word; execute
  // reads a7 and a0 for a possible ECALL; idle reads the requested index.
  always_comb begin
    case (state_r)
      S_IDLE: begin
        ra_idx = in_reg_index; rb_idx = 5'd0;
      end
      S_EXE: begin
        ra_idx = 5'd17; rb_idx = 5'd10;
      end
      default: begin
        ra_idx = data_r[19:15]; rb_idx = data_r[24:20];
      end
    endcase
  end

  assign maddr      = mbase_r + AW'(cnt_r);
  assign mreq.wr    = (state_r == S_MWR);
  assign mreq.wdata = wdata_r[{cnt_r[1:0], 3'b000} +: 8];

  rvis_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mreq),
    .addr     (maddr),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  rvis_regs #(.MEM_BYTES(MEM_BYTES)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra_idx  (ra_idx),
    .rb_idx  (rb_idx),
    .wr      (rfw),
    .ra_data (a_val),
    .rb_data (b_val)
  );

  assign busy = (state_r != S_IDLE) || clearing;

  logic [2:0] cnt_m1;
  assign cnt_m1 = cnt_r - 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= 32'd0;
      run_r   <= 1'b1;
      cause_r <= rvis_pkg::CAUSE_NONE;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: begin
          if (start && !clearing) begin
            char_v_r <= 1'b0;
            char_r   <= 8'd0;
            val_r    <= 32'd0;
            cnt_r    <= 3'd0;
            data_r   <= 32'd0;
            case (in_req_type)
              rvis_pkg::REQ_WRITE: begin
                if (in_rng({16'd0, in_mem_address}, 3'd4)) begin
                  mbase_r <= AW'(in_mem_address);
                  span_r  <= 3'd4;
                  wdata_r <= in_write_word;
                  ret_r   <= S_DONE;
                  state_r <= S_MWR;
                end else begin
                  state_r <= S_DONE;
                end
              end
              rvis_pkg::REQ_EXEC: begin
                if (!run_r) begin
                  state_r <= S_DONE;
                end else if (in_rng(pc_r, 3'd4)) begin
                  mbase_r <= AW'(pc_r);
                  span_r  <= 3'd4;
                  ret_r   <= S_DEC;
                  state_r <= S_MRD;
                end else begin
                  // Fetch out of range reads as zero: decodes as illegal.
                  state_r <= S_DEC;
                end
              end
              rvis_pkg::REQ_READ: state_r <= S_REG;
              default:            state_r <= S_DONE;
            endcase
          end
        end
        // Issue one byte read per cycle, collect the byte of the last one.
        S_MRD: begin
          if (cnt_r != 3'd0) begin
            data_r[{cnt_m1[1:0], 3'b000} +: 8] <= mem_rdata;
          end
          if (cnt_r == span_r) begin
            state_r <= ret_r;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_MWR: begin
          if (cnt_r == span_r - 3'd1) begin
            state_r <= ret_r;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_DEC: begin
          ins_r   <= data_r;
          state_r <= S_EXE;
        end
        S_EXE: begin
          state_r <= S_DONE;
          case (op)
            rvis_pkg::OP_LUI, rvis_pkg::OP_AUIPC,
            rvis_pkg::OP_IMM, rvis_pkg::OP_REG: pc_r <= pc4;
            rvis_pkg::OP_JAL: pc_r <= pc_r + imm_j;
            rvis_pkg::OP_JALR: begin
              if (f3 == 3'd0) begin
                pc_r <= (a_val + imm_i) & ~32'd1;
              end
            end
            rvis_pkg::OP_BRANCH: pc_r <= take ? pc_r + imm_b : pc4;
            rvis_pkg::OP_LOAD: begin
              pc_r <= pc4;
              if (ld_ok && in_rng(ld_addr, acc_span)) begin
                mbase_r <= AW'(ld_addr);
                span_r  <= acc_span;
                cnt_r   <= 3'd0;
                data_r  <= 32'd0;
                ret_r   <= S_LDW;
                state_r <= S_MRD;
              end
            end
            rvis_pkg::OP_STORE: begin
              pc_r <= pc4;
              if (f3 <= 3'd2 && in_rng(st_addr, acc_span)) begin
                mbase_r <= AW'(st_addr);
                span_r  <= acc_span;
                cnt_r   <= 3'd0;
                wdata_r <= b_val;
                ret_r   <= S_DONE;
                state_r <= S_MWR;
              end
            end
            rvis_pkg::OP_SYSTEM: begin
              pc_r <= pc4;
              if (ins_r == rvis_pkg::ECALL_WORD) begin
                state_r <= S_SYS;
              end
            end
            default: begin
              run_r   <= 1'b0;
              cause_r <= rvis_pkg::CAUSE_ILLEGAL;
            end
          endcase
        end
        // a_val holds a7, b_val holds a0 here.
        S_SYS: begin
          if (a_val == rvis_pkg::A7_PUTCHAR) begin
            char_v_r <= 1'b1;
            char_r   <= b_val[7:0];
          end else if (a_val == rvis_pkg::A7_EXIT) begin
            run_r   <= 1'b0;
            cause_r <= rvis_pkg::CAUSE_EXIT;
          end
          state_r <= S_DONE;
        end
        S_LDW:   state_r <= S_DONE;
        S_REG: begin
          val_r   <= a_val;
          state_r <= S_DONE;
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register: loaded from committed state as the item finishes.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      oh_r   <= !run_r;
      oc_r   <= cause_r;
      ocv_r  <= char_v_r;
      och_r  <= char_r;
      opc_r  <= pc_r;
      oval_r <= val_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_halted     = oh_r;
  assign out_halt_cause = oc_r;
  assign out_char_valid = ocv_r;
  assign out_char_out   = och_r;
  assign out_pc_now     = opc_r;
  assign out_reg_value  = oval_r;

endmodule

// File: rtl/rvis_mem.sv
// ---------------------------------------------------------------------------
// rvis_mem: byte-wide main memory
// One port, registered read; zero sweep after reset, one byte per cycle.
// ---------------------------------------------------------------------------
module rvis_mem #(
  parameter int MEM_BYTES = 65536,
  localparam int AW = $clog2(MEM_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rvis_pkg::mem_req_t req,
  input  logic [AW-1:0]     addr,
  output logic [7:0]        rdata,
  output logic              clearing
);

  localparam logic [AW-1:0] LAST = AW'(MEM_BYTES - 1);

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    rdata_r;
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= 8'd0;
    end else if (req.wr) begin
      mem[addr] <= req.wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata    = rdata_r;
  assign clearing = clr_r;

endmodule

// File: rtl/rvis_regs.sv
// ---------------------------------------------------------------------------
// rvis_regs: integer register file
// Two registered read ports, one write port; x0 reads zero.
// ---------------------------------------------------------------------------
module rvis_regs #(
  parameter int MEM_BYTES = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [4:0]      ra_idx,
  input  logic [4:0]      rb_idx,
  input  rvis_pkg::rf_wr_t wr,
  output logic [31:0]     ra_data,
  output logic [31:0]     rb_data
);

  localparam logic [31:0] SP_RESET = 32'(MEM_BYTES - 4);
  localparam logic [4:0]  SP_IDX   = 5'd2;

  logic [31:0] rf_mem [32];
  logic [31:0] valid_r;
  logic [31:0] ra_q_r, rb_q_r;
  logic [4:0]  ra_idx_r, rb_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rf_mem[wr.idx] <= wr.data;
    end
    ra_q_r   <= rf_mem[ra_idx];
    rb_q_r   <= rf_mem[rb_idx];
    ra_idx_r <= ra_idx;
    rb_idx_r <= rb_idx;
  end

  // Entries never written since reset read their reset value.
  function automatic logic [31:0] pick(input logic [4:0] idx, input logic vld,
                                       input logic [31:0] q);
    logic [31:0] r;
    if (idx == 5'd0) begin
      r = 32'd0;
    end else if (vld) begin
      r = q;
    end else if (idx == SP_IDX) begin
      r = SP_RESET;
    end else begin
      r = 32'd0;
    end
    return r;
  endfunction

  assign ra_data = pick(ra_idx_r, valid_r[ra_idx_r], ra_q_r);
  assign rb_data = pick(rb_idx_r, valid_r[rb_idx_r], rb_q_r);

endmodule

// File: bench/tb_rv32i_instruction_step.sv
// ---------------------------------------------------------------------------
// tb_rv32i_instruction_step: self-checking bench for the request-driven core
// Walks a short table of directed items and then builds random programs one
// instruction at a time: write it at the pc, execute it, read registers and
// poke data. A behavioral core model predicts each untyped result. The run
// ends by halting the core one of three ways and probing it once stopped.
// ---------------------------------------------------------------------------
module tb_rv32i_instruction_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MEMSZ    = 65536;
  localparam logic [1:0]  REQ_NOP  = 2'd3;
  localparam logic [6:0]  OP_BAD   = 7'h7F;
  localparam logic [31:0] PC_CEIL  = 32'h0000_FF00;
  localparam int          WD_LIMIT = 200000;
  localparam int          N_RAND   = 400;

  typedef struct packed {
    logic        halted;
    logic [1:0]  cause;
    logic        cv;
    logic [7:0]  ch;
    logic [31:0] pc;
    logic [31:0] rv;
  } step_res_t;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] addr;
    logic [31:0] word;
    logic [4:0]  idx;
    bit          typed;
    step_res_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_mem_address = '0;
  logic [31:0] in_write_word = '0;
  logic [4:0]  in_reg_index = '0;
  logic        out_valid;
  logic        out_halted;
  logic [1:0]  out_halt_cause;
  logic        out_char_valid;
  logic [7:0]  out_char_out;
  logic [31:0] out_pc_now;
  logic [31:0] out_reg_value;

  // shadow core state
  logic [31:0] core_pc;
  logic [31:0] core_regs [32];
  logic [7:0]  core_mem [MEMSZ];
  logic        core_run;
  logic [1:0]  core_cause;

  step_res_t   pending_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          took;
  bit          calm = 1'b0;
  dir_row_t    dir_tab [21];

  always #5 clk = ~clk;

  rv32i_instruction_step dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_mem_address(in_mem_address),
    .in_write_word(in_write_word), .in_reg_index(in_reg_index),
    .out_valid(out_valid), .out_halted(out_halted),
    .out_halt_cause(out_halt_cause), .out_char_valid(out_char_valid),
    .out_char_out(out_char_out), .out_pc_now(out_pc_now),
    .out_reg_value(out_reg_value)
  );

  // ---- shadow core ---------------------------------------------------------

  function automatic bit fits(logic [31:0] addr, int span);
    return (longint'(addr) + span) <= MEMSZ;
  endfunction

  function automatic logic [31:0] mem_load(logic [31:0] addr, int span);
    logic [31:0] v;
    v = '0;
    if (!fits(addr, span)) return '0;
    for (int i = 0; i < span; i++) v |= 32'(core_mem[addr + i]) << (8 * i);
    return v;
  endfunction

  function automatic void mem_store(logic [31:0] addr, int span, logic [31:0] v);
    if (!fits(addr, span)) return;
    for (int i = 0; i < span; i++) core_mem[addr + i] = v[8*i +: 8];
  endfunction

  function automatic logic [31:0] reg_get(logic [4:0] n);
    return (n == 0) ? '0 : core_regs[n];
  endfunction

  function automatic void reg_put(logic [4:0] n, logic [31:0] v);
    if (n != 0) core_regs[n] = v;
  endfunction

  // Run one instruction at the pc; returns {emitted, char}.
  function automatic logic [8:0] run_instr();
    logic [31:0] ins, a, b, imm_i, imm_s, imm_u, imm_b, imm_j, npc, ea, r;
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        alt, take;
    logic [8:0]  emit;
    ins   = mem_load(core_pc, 4);
    op    = ins[6:0];
    rd    = ins[11:7];
    f3    = ins[14:12];
    a     = reg_get(ins[19:15]);
    b     = reg_get(ins[24:20]);
    alt   = ins[30];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_u = {ins[31:12], 12'b0};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    npc   = core_pc + 4;
    emit  = '0;
    take  = 1'b0;
    r     = '0;
    case (op)
      rvis_pkg::OP_LUI:   reg_put(rd, imm_u);
      rvis_pkg::OP_AUIPC: reg_put(rd, core_pc + imm_u);
      rvis_pkg::OP_JAL: begin
        reg_put(rd, npc);
        npc = core_pc + imm_j;
      end
      rvis_pkg::OP_JALR: begin
        // nonzero funct3 leaves even the pc alone
        if (f3 != 0) return '0;
        ea = (a + imm_i) & ~32'd1;
        reg_put(rd, npc);
        npc = ea;
      end
      rvis_pkg::OP_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = ($signed(a) < $signed(b));
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: take = 1'b0;
        endcase
        if (take) npc = core_pc + imm_b;
      end
      rvis_pkg::OP_LOAD: begin
        ea = a + imm_i;
        case (f3)
          3'd0: begin r = mem_load(ea, 1); reg_put(rd, {{24{r[7]}}, r[7:0]}); end
          3'd1: begin r = mem_load(ea, 2); reg_put(rd, {{16{r[15]}}, r[15:0]}); end
          3'd2: reg_put(rd, mem_load(ea, 4));
          3'd4: reg_put(rd, mem_load(ea, 1));
          3'd5: reg_put(rd, mem_load(ea, 2));
          default: ;
        endcase
      end
      rvis_pkg::OP_STORE: begin
        ea = a + imm_s;
        if (f3 == 0) mem_store(ea, 1, b);
        else if (f3 == 1) mem_store(ea, 2, b);
        else if (f3 == 2) mem_store(ea, 4, b);
      end
      rvis_pkg::OP_IMM, rvis_pkg::OP_REG: begin
        if (op == rvis_pkg::OP_IMM) begin
          b = imm_i;
          if (f3 != 5) alt = 1'b0;
        end
        case (f3)
          3'd0: r = alt ? a - b : a + b;
          3'd1: r = a << b[4:0];
          3'd2: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          3'd3: r = (a < b) ? 32'd1 : 32'd0;
          3'd4: r = a ^ b;
          3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
          3'd6: r = a | b;
          default: r = a & b;
        endcase
        reg_put(rd, r);
      end
      rvis_pkg::OP_SYSTEM: begin
        if (ins == rvis_pkg::ECALL_WORD) begin
          if (core_regs[17] == rvis_pkg::A7_PUTCHAR) begin
            emit = {1'b1, core_regs[10][7:0]};
          end else if (core_regs[17] == rvis_pkg::A7_EXIT) begin
            core_run   = 1'b0;
            core_cause = rvis_pkg::CAUSE_EXIT;
          end
        end
      end
      default: begin
        // unknown opcode, word 0 included: stop with the pc held
        core_run   = 1'b0;
        core_cause = rvis_pkg::CAUSE_ILLEGAL;
        return '0;
      end
    endcase
    core_pc = npc;
    return emit;
  endfunction

  function automatic step_res_t core_step(logic [1:0] req, logic [15:0] addr,
                                          logic [31:0] word, logic [4:0] idx);
    step_res_t  res;
    logic [8:0] emit;
    emit = '0;
    res  = '0;
    if (req == rvis_pkg::REQ_WRITE) mem_store(32'(addr), 4, word);
    else if (req == rvis_pkg::REQ_EXEC) begin
      if (core_run) emit = run_instr();
    end else if (req == rvis_pkg::REQ_READ) res.rv = reg_get(idx);
    res.halted = !core_run;
    res.cause  = core_cause;
    res.cv     = emit[8];
    res.ch     = emit[7:0];
    res.pc     = core_pc;
    return res;
  endfunction

  // ---- instruction builder -------------------------------------------------

  function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [31:0] off);
    return {off[20], off[10:1], off[11], off[19:12], rd, rvis_pkg::OP_JAL};
  endfunction

  function automatic logic [31:0] enc_branch(logic [2:0] f3, logic [4:0] rs1,
                                             logic [4:0] rs2, logic [31:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rvis_pkg::OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_addi(logic [4:0] rd, logic [11:0] imm);
    return {imm, 5'd0, 3'd0, rd, rvis_pkg::OP_IMM};
  endfunction

  // Random instruction that keeps the pc inside memory and the core running.
  function automatic logic [31:0] pick_instr();
    logic [31:0] w, tgt, lo, hi;
    int          k;
    w = $urandom;
    if (core_pc > PC_CEIL) begin
      return enc_jal(w[11:7], ($urandom_range(0, PC_CEIL) & ~1) - core_pc);
    end
    k = $urandom_range(0, 11);
    case (k)
      0: w[6:0] = rvis_pkg::OP_LUI;
      1: w[6:0] = rvis_pkg::OP_AUIPC;
      2: w = enc_jal(w[11:7], ($urandom_range(0, PC_CEIL) & ~1) - core_pc);
      3: begin
        w[6:0] = rvis_pkg::OP_JALR;
        w[14:12] = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        tgt = (reg_get(w[19:15]) + {{20{w[31]}}, w[31:20]}) & ~32'd1;
        if (tgt > PC_CEIL) begin
          w[19:15] = 5'd0;
          w[31]    = 1'b0;
        end
      end
      4: begin
        lo = (core_pc > 4094) ? core_pc - 4094 : 32'd0;
        hi = (core_pc + 4094 < PC_CEIL) ? core_pc + 4094 : PC_CEIL;
        tgt = $urandom_range(lo, hi) & ~1;
        w = enc_branch(w[14:12], w[19:15], w[24:20], tgt - core_pc);
      end
      5, 6: begin
        w[6:0] = (k == 5) ? rvis_pkg::OP_LOAD : rvis_pkg::OP_STORE;
        // bias the base toward in-range addresses: zero or the stack top
        case ($urandom_range(0, 2))
          0: ;
          1: begin w[19:15] = 5'd0; w[31] = 1'b0; end
          default: w[19:15] = 5'd2;
        endcase
      end
      7: w[6:0] = rvis_pkg::OP_IMM;
      8: w[6:0] = rvis_pkg::OP_REG;
      9: begin
        w = ($urandom_range(0, 2) != 0) ? rvis_pkg::ECALL_WORD
                                         : {w[31:7], rvis_pkg::OP_SYSTEM};
      end
      10: w = enc_addi(5'd17, 12'd1);
      default: w = enc_addi(5'd10, {4'd0, w[31:24]});
    endcase
    // hold the exit call back for the end of the run
    if (w == rvis_pkg::ECALL_WORD && core_regs[17] == rvis_pkg::A7_EXIT) begin
      w = enc_addi(5'd17, 12'd1);
    end
    return w;
  endfunction

  // ---- driver --------------------------------------------------------------

  task automatic send(logic [1:0] req, logic [15:0] addr, logic [31:0] word,
                      logic [4:0] idx, bit typed = 0, step_res_t typed_res = '0);
    step_res_t pred;
    int        gap;
    int        r;
    start          <= 1'b1;
    in_req_type    <= req;
    in_mem_address <= addr;
    in_write_word  <= word;
    in_reg_index   <= idx;
    do @(posedge clk); while (busy);
    pred = core_step(req, addr, word, idx);
    pending_q.push_back(typed ? typed_res : pred);
    r   = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_instr_at_pc(logic [31:0] w);
    send(rvis_pkg::REQ_WRITE, core_pc[15:0], w, 5'($urandom));
    send(rvis_pkg::REQ_EXEC, 16'($urandom), 32'($urandom), 5'($urandom));
  endtask

  // ---- result checker ------------------------------------------------------

  task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    step_res_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual pc %h", $time, out_pc_now);
        errors++;
      end else begin
        e = pending_q.pop_front();
        check_field("halted", 32'(e.halted), 32'(out_halted));
        check_field("halt_cause", 32'(e.cause), 32'(out_halt_cause));
        check_field("char_valid", 32'(e.cv), 32'(out_char_valid));
        check_field("char_out", 32'(e.ch), 32'(out_char_out));
        check_field("pc_now", e.pc, out_pc_now);
        check_field("reg_value", e.rv, out_reg_value);
      end
    end
  end

  // Watchdog: count cycles with no item taken and no result seen. The limit
  // covers the memory sweep after reset plus the longest idle gap.
  always @(posedge clk) begin
    took = (start && !busy) || out_valid;
    idle_cycles = took ? 0 : idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---- stimulus ------------------------------------------------------------

  function automatic dir_row_t row(logic [1:0] req, logic [15:0] addr,
                                   logic [31:0] word, logic [4:0] idx);
    dir_row_t d;
    d.req = req; d.addr = addr; d.word = word; d.idx = idx;
    d.typed = 1'b0; d.res = '0;
    return d;
  endfunction

  initial begin
    int n;
    int k;

    core_pc = '0;
    foreach (core_regs[i]) core_regs[i] = '0;
    core_regs[2] = 32'(MEMSZ - 4);
    foreach (core_mem[i]) core_mem[i] = '0;
    core_run   = 1'b1;
    core_cause = rvis_pkg::CAUSE_NONE;

    // Status rows up front carry typed results; the program rows rely on
    // the model. The program: set a7 = 1 and a0 = 'A', print it, build a
    // sign bit and spread it with srai, store a halfword at the very top of
    // memory, load a word that runs three bytes off the end, and write a jalr
    // with a nonzero funct3 that the seven execute rows never reach.
    dir_tab[0]  = row(rvis_pkg::REQ_READ, 16'h0000, 32'h0, 5'd2);
    dir_tab[0].typed = 1'b1;
    dir_tab[0].res.rv = 32'(MEMSZ - 4);
    dir_tab[1]  = row(rvis_pkg::REQ_READ, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
    dir_tab[1].typed = 1'b1;
    dir_tab[2]  = row(REQ_NOP, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    dir_tab[2].typed = 1'b1;
    dir_tab[3]  = row(rvis_pkg::REQ_WRITE, 16'hFFFC, 32'hFFFF_FFFF, 5'd31);
    dir_tab[3].typed = 1'b1;
    dir_tab[4]  = row(rvis_pkg::REQ_WRITE, 16'hFFFD, 32'h1234_5678, 5'd0);
    dir_tab[4].typed = 1'b1;
    dir_tab[5]  = row(rvis_pkg::REQ_WRITE, 16'd0, enc_addi(5'd17, 12'd1), 5'd0);
    dir_tab[6]  = row(rvis_pkg::REQ_WRITE, 16'd4, enc_addi(5'd10, 12'h041), 5'd0);
    dir_tab[7]  = row(rvis_pkg::REQ_WRITE, 16'd8, rvis_pkg::ECALL_WORD, 5'd0);
    dir_tab[8]  = row(rvis_pkg::REQ_WRITE, 16'd12,
                      {20'h80000, 5'd5, rvis_pkg::OP_LUI}, 5'd0);
    dir_tab[9]  = row(rvis_pkg::REQ_WRITE, 16'd16,
                      {7'h20, 5'd31, 5'd5, 3'd5, 5'd6, rvis_pkg::OP_IMM}, 5'd0);
    dir_tab[10] = row(rvis_pkg::REQ_WRITE, 16'd20,
                      {7'd0, 5'd6, 5'd2, 3'd1, 5'd2, rvis_pkg::OP_STORE}, 5'd0);
    dir_tab[11] = row(rvis_pkg::REQ_WRITE, 16'd24,
                      {12'd3, 5'd2, 3'd2, 5'd7, rvis_pkg::OP_LOAD}, 5'd0);
    dir_tab[12] = row(rvis_pkg::REQ_WRITE, 16'd28,
                      {12'd0, 5'd0, 3'd1, 5'd1, rvis_pkg::OP_JALR}, 5'd0);
    for (int i = 0; i < 7; i++) begin
      dir_tab[13 + i] = row(rvis_pkg::REQ_EXEC, 16'h0, 32'h0, 5'd0);
    end
    dir_tab[20] = row(rvis_pkg::REQ_READ, 16'h0, 32'h0, 5'd6);

    // hold reset, then release it; the sweep behind it keeps busy high
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send(dir_tab[i].req, dir_tab[i].addr, dir_tab[i].word, dir_tab[i].idx,
           dir_tab[i].typed, dir_tab[i].res);

    // Random part: mostly well-formed program steps, with register reads,
    // stray data writes and status probes in between.
    n = 0;
    while (n < N_RAND) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      if (k < 60) begin
        run_instr_at_pc(pick_instr());
        n += 2;
      end else begin
        if (k < 80) begin
          send(rvis_pkg::REQ_READ, 16'($urandom), 32'($urandom), 5'($urandom));
        end else if (k < 93) begin
          send(rvis_pkg::REQ_WRITE, 16'($urandom), 32'($urandom), 5'($urandom));
        end else begin
          send(REQ_NOP, 16'($urandom), 32'($urandom), 5'($urandom));
        end
        n++;
      end
    end

    // Stop the core one of three ways, then probe the halted core.
    calm = 1'b0;
    case ($urandom_range(0, 2))
      0: run_instr_at_pc({25'($urandom_range(0, 32'h01FF_FFFF)), OP_BAD});
      1: run_instr_at_pc(32'h0);
      default: begin
        run_instr_at_pc(enc_addi(5'd17, 12'd10));
        run_instr_at_pc(rvis_pkg::ECALL_WORD);
      end
    endcase
    run_instr_at_pc(enc_addi(5'd1, 12'd1));
    send(rvis_pkg::REQ_READ, 16'h0, 32'h0, 5'd17);
    send(rvis_pkg::REQ_WRITE, 16'h0100, 32'hA5A5_5A5A, 5'd0);
    send(REQ_NOP, 16'h0, 32'h0, 5'd0);
    start <= 1'b0;

    // drain, then give the longest request time to show a stray result
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rvis_pkg.sv
rtl/rvis_mem.sv
rtl/rvis_regs.sv
rtl/rv32i_instruction_step.sv
bench/tb_rv32i_instruction_step.sv
